// ===== hw/rtl/psw_pkg.sv =====
// shared types and constants for the priority schedule wait-time core
// no dependencies
`default_nettype none
package psw_pkg;

	localparam int MAX_JOBS = 16;
	localparam int IDX_W    = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
	localparam int CNT_W    = $clog2(MAX_JOBS + 1);
	localparam int ID_W     = 5;
	localparam int BURST_W  = 16;
	localparam int PRIO_W   = 8;
	localparam int TIME_W   = 20;
	localparam int AVG_W    = 28;
	localparam int FRAC_W   = 8;
	localparam int SUM_W    = 30;
	localparam int DIVD_W   = SUM_W + FRAC_W;

	typedef struct packed {
		logic [ID_W-1:0]    id;
		logic [PRIO_W-1:0]  prio;
		logic [BURST_W-1:0] burst;
	} job_t;

	typedef enum logic {
		WS_IN,
		WS_HOLD
	} wsel_t;

	typedef struct packed {
		logic             mem_we;
		logic [IDX_W-1:0] waddr;
		wsel_t            wsel;
		logic [ID_W-1:0]  in_id;
		logic             mem_re;
		logic [IDX_W-1:0] raddr;
		logic             load_hold;
		logic             row_clr;
		logic             row_step;
		logic             out_load;
		logic             out_show;
		logic             avg_load;
		logic             last;
		logic             drop;
		logic             div_start;
	} psw_cmd_t;

	typedef struct packed {
		logic gt;
		logic out_busy;
		logic div_done;
	} psw_sts_t;

endpackage
`default_nettype wire

// ===== hw/rtl/psw_div.sv =====
// restoring divider, two dividends over one shared divisor, one bit per cycle
// depends on psw_pkg
`default_nettype none
module psw_div import psw_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire logic [DIVD_W-1:0] dividend_a,
	input  wire logic [DIVD_W-1:0] dividend_b,
	input  wire logic [CNT_W-1:0]  divisor,
	output logic      [DIVD_W-1:0] quot_a,
	output logic      [DIVD_W-1:0] quot_b,
	output logic                   done
);

	localparam int STEP_W = $clog2(DIVD_W + 1);

	logic [DIVD_W-1:0] qa_q, qb_q;
	logic [CNT_W:0]    ra_q, rb_q;
	logic [CNT_W-1:0]  dv_q;
	logic [STEP_W-1:0] step_q;
	logic              busy_q, done_q;
	logic [CNT_W:0]    sa, sb;
	logic              ka, kb;

	always_comb begin
		sa = {ra_q[CNT_W-1:0], qa_q[DIVD_W-1]};
		sb = {rb_q[CNT_W-1:0], qb_q[DIVD_W-1]};
		ka = sa >= {1'b0, dv_q};
		kb = sb >= {1'b0, dv_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= STEP_W'(DIVD_W);
			end else if (busy_q) begin
				step_q <= step_q - 1'b1;
				if (step_q == STEP_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			qa_q <= dividend_a;
			qb_q <= dividend_b;
			ra_q <= '0;
			rb_q <= '0;
			dv_q <= divisor;
		end else if (busy_q) begin
			ra_q <= ka ? sa - {1'b0, dv_q} : sa;
			rb_q <= kb ? sb - {1'b0, dv_q} : sb;
			qa_q <= {qa_q[DIVD_W-2:0], ka};
			qb_q <= {qb_q[DIVD_W-2:0], kb};
		end
	end

	assign quot_a = qa_q;
	assign quot_b = qb_q;
	assign done   = done_q;

endmodule
`default_nettype wire

// ===== hw/rtl/psw_dp.sv =====
// datapath: job memory, sort holding register, row timing sums, output register
// depends on psw_pkg and psw_div
`default_nettype none
module psw_dp import psw_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire psw_cmd_t           cmd,
	output psw_sts_t                sts,
	input  wire logic [CNT_W-1:0]   n_jobs,
	input  wire logic [BURST_W-1:0] burst_time,
	input  wire logic [PRIO_W-1:0]  job_priority,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic [ID_W-1:0]         job_id,
	output logic [BURST_W-1:0]      job_burst,
	output logic [PRIO_W-1:0]       job_prio,
	output logic [TIME_W-1:0]       wait_time,
	output logic [TIME_W-1:0]       turnaround,
	output logic [AVG_W-1:0]        avg_wait_q8,
	output logic [AVG_W-1:0]        avg_turn_q8,
	output logic                    last_row,
	output logic                    overflowed
);

	job_t mem [MAX_JOBS];
	job_t rdata_q, hold_q, wdata;
	logic [SUM_W-1:0] wait_q, sumw_q, sumt_q, turn;
	logic [DIVD_W-1:0] qa, qb;
	logic div_done, valid_q;

	function automatic logic [TIME_W-1:0] sat_t(input logic [SUM_W-1:0] v);
		return (|v[SUM_W-1:TIME_W]) ? '1 : v[TIME_W-1:0];
	endfunction

	function automatic logic [AVG_W-1:0] sat_a(input logic [DIVD_W-1:0] v);
		return (|v[DIVD_W-1:AVG_W]) ? '1 : v[AVG_W-1:0];
	endfunction

	assign wdata = (cmd.wsel == WS_IN) ? job_t'{cmd.in_id, job_priority, burst_time} : hold_q;
	assign turn  = wait_q + SUM_W'(rdata_q.burst);

	always_ff @(posedge clk) begin
		if (cmd.mem_we)
			mem[cmd.waddr] <= wdata;
		if (cmd.mem_re)
			rdata_q <= mem[cmd.raddr];
		if (cmd.load_hold)
			hold_q <= rdata_q;
		if (cmd.row_clr) begin
			wait_q <= '0;
			sumw_q <= '0;
			sumt_q <= '0;
		end else if (cmd.row_step) begin
			wait_q <= turn;
			sumw_q <= sumw_q + wait_q;
			sumt_q <= sumt_q + turn;
		end
		if (cmd.out_load) begin
			job_id      <= rdata_q.id;
			job_burst   <= rdata_q.burst;
			job_prio    <= rdata_q.prio;
			wait_time   <= sat_t(wait_q);
			turnaround  <= sat_t(turn);
			avg_wait_q8 <= '0;
			avg_turn_q8 <= '0;
			last_row    <= cmd.last;
			overflowed  <= cmd.drop;
		end else if (cmd.avg_load) begin
			avg_wait_q8 <= sat_a(qa);
			avg_turn_q8 <= sat_a(qb);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (cmd.out_show || cmd.avg_load) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	psw_div u_div (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (cmd.div_start),
		.dividend_a ({sumw_q, FRAC_W'(0)}),
		.dividend_b ({sumt_q, FRAC_W'(0)}),
		.divisor    (n_jobs),
		.quot_a     (qa),
		.quot_b     (qb),
		.done       (div_done)
	);

	assign out_valid    = valid_q;
	assign sts.gt       = hold_q.prio > rdata_q.prio;
	assign sts.out_busy = valid_q;
	assign sts.div_done = div_done;

endmodule
`default_nettype wire

// ===== hw/rtl/psw_ctrl.sv =====
// controller: job loading, exchange sort sequencing, row emission
// depends on psw_pkg
`default_nettype none
module psw_ctrl import psw_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_ready,
	input  wire logic             final_job,
	output psw_cmd_t              cmd,
	input  wire psw_sts_t         sts,
	output logic [CNT_W-1:0]      n_jobs
);

	typedef enum logic [3:0] {
		ST_IDLE, ST_RDI, ST_LDA, ST_RDJ, ST_CMP, ST_WRI,
		ST_ERD, ST_EROW, ST_DVS, ST_DV, ST_EWT
	} state_t;

	state_t state_q;
	logic [CNT_W-1:0] cnt_q, i_q, j_q, k_q;
	logic [ID_W-1:0]  arr_q;
	logic             drop_q;
	logic             room, acc, k_last;
	logic [CNT_W:0]   cnt_n;

	assign in_ready = state_q == ST_IDLE;
	assign acc      = in_valid && in_ready;
	assign room     = cnt_q < CNT_W'(MAX_JOBS);
	assign cnt_n    = {1'b0, cnt_q} + {{CNT_W{1'b0}}, room};
	assign k_last   = ({1'b0, k_q} + 1'b1) == {1'b0, cnt_q};
	assign n_jobs   = cnt_q;

	always_comb begin
		cmd       = '0;
		cmd.wsel  = WS_HOLD;
		cmd.in_id = arr_q + 1'b1;
		cmd.last  = k_last;
		cmd.drop  = drop_q;
		case (state_q)
			ST_IDLE: begin
				cmd.mem_we = acc && room;
				cmd.waddr  = cnt_q[IDX_W-1:0];
				cmd.wsel   = WS_IN;
				cmd.row_clr = 1'b1;
			end
			ST_RDI: begin
				cmd.mem_re = 1'b1;
				cmd.raddr  = i_q[IDX_W-1:0];
			end
			ST_LDA: cmd.load_hold = 1'b1;
			ST_RDJ: begin
				cmd.mem_re = 1'b1;
				cmd.raddr  = j_q[IDX_W-1:0];
			end
			ST_CMP: begin
				// exchange: held entry goes to slot j, slot j's entry is held
				cmd.mem_we    = sts.gt;
				cmd.waddr     = j_q[IDX_W-1:0];
				cmd.load_hold = sts.gt;
			end
			ST_WRI: begin
				cmd.mem_we = 1'b1;
				cmd.waddr  = i_q[IDX_W-1:0];
				cmd.row_clr = 1'b1;
			end
			ST_ERD: begin
				cmd.mem_re = 1'b1;
				cmd.raddr  = k_q[IDX_W-1:0];
			end
			ST_EROW: begin
				cmd.out_load = 1'b1;
				cmd.row_step = 1'b1;
				cmd.out_show = !k_last;
			end
			ST_DVS: cmd.div_start = 1'b1;
			ST_DV: cmd.avg_load = sts.div_done;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			arr_q   <= '0;
			drop_q  <= 1'b0;
			i_q     <= '0;
			j_q     <= '0;
			k_q     <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (acc) begin
						arr_q <= arr_q + 1'b1;
						cnt_q <= cnt_n[CNT_W-1:0];
						if (!room)
							drop_q <= 1'b1;
						i_q <= '0;
						k_q <= '0;
						if (final_job)
							state_q <= (cnt_n > (CNT_W+1)'(1)) ? ST_RDI : ST_ERD;
					end
				end
				ST_RDI: state_q <= ST_LDA;
				ST_LDA: begin
					j_q     <= i_q + 1'b1;
					state_q <= ST_RDJ;
				end
				ST_RDJ: state_q <= ST_CMP;
				ST_CMP: begin
					j_q     <= j_q + 1'b1;
					state_q <= (({1'b0, j_q} + 1'b1) == {1'b0, cnt_q}) ? ST_WRI : ST_RDJ;
				end
				ST_WRI: begin
					i_q     <= i_q + 1'b1;
					state_q <= (({1'b0, i_q} + 2'd2) < {1'b0, cnt_q}) ? ST_RDI : ST_ERD;
				end
				ST_ERD: state_q <= ST_EROW;
				ST_EROW: state_q <= k_last ? ST_DVS : ST_EWT;
				ST_DVS: state_q <= ST_DV;
				ST_DV: begin
					if (sts.div_done)
						state_q <= ST_EWT;
				end
				ST_EWT: begin
					if (!sts.out_busy) begin
						if (k_last) begin
							cnt_q   <= '0;
							arr_q   <= '0;
							drop_q  <= 1'b0;
							state_q <= ST_IDLE;
						end else begin
							k_q     <= k_q + 1'b1;
							state_q <= ST_ERD;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire

// ===== hw/rtl/priority_schedule_wait_times_core.sv =====
// top level of the non-preemptive priority scheduler
// depends on psw_pkg, psw_ctrl and psw_dp
`default_nettype none
// Jobs arrive one per transfer (burst time, priority, final mark) and are stored in a
// 16-entry job memory with ids counted from 1 in arrival order; jobs past capacity are
// dropped and flagged on every row. While loading, a job can be taken every clock. The
// transfer that carries the final mark starts the schedule: an exchange sort over the
// single-port job memory, then one row per job in priority order, each row held in the
// output register until it is taken. The last row carries the truncated Q8 averages,
// which come from a bit-serial divider. No new job is taken until the schedule has been
// fully delivered.
module priority_schedule_wait_times_core import psw_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic [BURST_W-1:0] burst_time,
	input  wire logic [PRIO_W-1:0]  job_priority,
	input  wire logic               final_job,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic [ID_W-1:0]         job_id,
	output logic [BURST_W-1:0]      job_burst,
	output logic [PRIO_W-1:0]       job_prio,
	output logic [TIME_W-1:0]       wait_time,
	output logic [TIME_W-1:0]       turnaround,
	output logic [AVG_W-1:0]        avg_wait_q8,
	output logic [AVG_W-1:0]        avg_turn_q8,
	output logic                    last_row,
	output logic                    overflowed
);

	psw_cmd_t         cmd;
	psw_sts_t         sts;
	logic [CNT_W-1:0] n_jobs;

	// sequencing of load, sort and row emission
	psw_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.final_job (final_job),
		.cmd       (cmd),
		.sts       (sts),
		.n_jobs    (n_jobs)
	);

	// job memory, sums, divider and output register
	psw_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.n_jobs       (n_jobs),
		.burst_time   (burst_time),
		.job_priority (job_priority),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.job_id       (job_id),
		.job_burst    (job_burst),
		.job_prio     (job_prio),
		.wait_time    (wait_time),
		.turnaround   (turnaround),
		.avg_wait_q8  (avg_wait_q8),
		.avg_turn_q8  (avg_turn_q8),
		.last_row     (last_row),
		.overflowed   (overflowed)
	);

endmodule
`default_nettype wire
